@@ hw/rtl/mvf_pkg.sv @@
// shared constants and the x.25 checksum step for the mavlink v1 framer
package mvf_pkg;

    localparam logic [7:0]  STX_BYTE        = 8'hFE;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;

    localparam int          RESULTS_MAX     = 8;
    localparam int          CNT_WIDTH       = $clog2(RESULTS_MAX + 1);
    localparam int          CFG_INDEX_WIDTH = 1;
    localparam int          CFG_DATA_WIDTH  = 8;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOURCE_SYSTEM    = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SOURCE_COMPONENT = 1'b1;

    localparam logic CMD_START   = 1'b0;
    localparam logic CMD_PAYLOAD = 1'b1;

    localparam logic [7:0] SYS_RESET  = 8'd255;
    localparam logic [7:0] COMP_RESET = 8'd190;

    // one byte of the mcrf4xx checksum
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0]  t;
        logic [15:0] w;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        w = {8'h00, t};
        return {8'h00, crc[15:8]} ^ (w << 8) ^ (w << 3) ^ (w >> 4);
    endfunction

endpackage

@@ hw/rtl/mavlink_v1_framer.sv @@
// mavlink v1 frame serialiser with header, payload echo and x.25 checksum
// the first byte of a transaction's results appears in the cycle after it is accepted
// throughput: one output byte per cycle unless out_stall; a start gives 6 or 8 bytes,
//   a payload byte 1 or 3, so a new input transaction is taken on the cycle the last
//   pending byte is taken; the result shift buffer (8 bytes) sets that rate
// reset (rst_n low, asynchronous): no frame open, checksum 0xffff, sequence 0, ids 255/190
module mavlink_v1_framer
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write_en,
    input  logic [mvf_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  logic [mvf_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  command,
    input  logic [7:0]                            message_id,
    input  logic [7:0]                            crc_extra,
    input  logic [7:0]                            payload_length,
    input  logic [7:0]                            data_byte,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [7:0]                            out_byte,
    output logic                                  frame_end,
    output logic                                  error
);

    // configuration registers
    logic [7:0] sys_reg;
    logic [7:0] comp_reg;

    // frame state
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  extra_reg, extra_next;
    logic        open_reg, open_next;

    // result shift buffer
    logic [7:0]                      buf_reg [mvf_pkg::RESULTS_MAX];
    logic [7:0]                      buf_next [mvf_pkg::RESULTS_MAX];
    logic [mvf_pkg::CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic                            end_reg, end_next;
    logic                            err_reg, err_next;

    logic in_take;
    logic out_take;
    logic load_ok;

    // checksum chain
    logic [15:0] h1, h2, h3, h4, h5, h6;
    logic [15:0] p1, p2;

    // handshake
    assign out_valid = (cnt_reg != '0);
    assign out_take  = out_valid && !out_stall;
    assign load_ok   = (cnt_reg == '0) ||
                       (cnt_reg == mvf_pkg::CNT_WIDTH'(1) && !out_stall);
    assign in_stall  = !load_ok;
    assign in_take   = in_valid && load_ok;

    // output fields
    assign out_byte  = buf_reg[0];
    assign frame_end = end_reg && (cnt_reg == mvf_pkg::CNT_WIDTH'(1));
    assign error     = err_reg;

    // header and payload checksum steps
    always_comb
    begin
        h1 = mvf_pkg::crc_fold(mvf_pkg::CRC_INIT, payload_length);
        h2 = mvf_pkg::crc_fold(h1, seq_reg);
        h3 = mvf_pkg::crc_fold(h2, sys_reg);
        h4 = mvf_pkg::crc_fold(h3, comp_reg);
        h5 = mvf_pkg::crc_fold(h4, message_id);
        h6 = mvf_pkg::crc_fold(h5, crc_extra);
        p1 = mvf_pkg::crc_fold(crc_reg, data_byte);
        p2 = mvf_pkg::crc_fold(p1, extra_reg);
    end

    // next state and result buffer
    always_comb
    begin
        crc_next   = crc_reg;
        seq_next   = seq_reg;
        rem_next   = rem_reg;
        extra_next = extra_reg;
        open_next  = open_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        cnt_next   = cnt_reg;
        for (int i = 0; i < mvf_pkg::RESULTS_MAX; i++)
        begin
            buf_next[i] = buf_reg[i];
        end

        // shift out a taken byte
        if (out_take)
        begin
            for (int i = 0; i < mvf_pkg::RESULTS_MAX - 1; i++)
            begin
                buf_next[i] = buf_reg[i+1];
            end
            cnt_next = cnt_reg - mvf_pkg::CNT_WIDTH'(1);
        end

        // load the results of a new transaction
        if (in_take)
        begin
            end_next = 1'b0;
            err_next = 1'b0;
            if (command == mvf_pkg::CMD_START)
            begin
                buf_next[0] = mvf_pkg::STX_BYTE;
                buf_next[1] = payload_length;
                buf_next[2] = seq_reg;
                buf_next[3] = sys_reg;
                buf_next[4] = comp_reg;
                buf_next[5] = message_id;
                buf_next[6] = h6[7:0];
                buf_next[7] = h6[15:8];
                seq_next    = 8'(seq_reg + 8'd1);
                extra_next  = crc_extra;
                rem_next    = payload_length;
                if (payload_length == 8'd0)
                begin
                    cnt_next  = mvf_pkg::CNT_WIDTH'(8);
                    end_next  = 1'b1;
                    crc_next  = h6;
                    open_next = 1'b0;
                end
                else
                begin
                    cnt_next  = mvf_pkg::CNT_WIDTH'(6);
                    crc_next  = h5;
                    open_next = 1'b1;
                end
            end
            else if (!open_reg)
            begin
                // payload byte with no frame open
                buf_next[0] = 8'd0;
                cnt_next    = mvf_pkg::CNT_WIDTH'(1);
                err_next    = 1'b1;
            end
            else
            begin
                buf_next[0] = data_byte;
                buf_next[1] = p2[7:0];
                buf_next[2] = p2[15:8];
                rem_next    = 8'(rem_reg - 8'd1);
                if (rem_reg == 8'd1)
                begin
                    cnt_next  = mvf_pkg::CNT_WIDTH'(3);
                    end_next  = 1'b1;
                    crc_next  = p2;
                    open_next = 1'b0;
                end
                else
                begin
                    cnt_next = mvf_pkg::CNT_WIDTH'(1);
                    crc_next = p1;
                end
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_reg  <= mvf_pkg::SYS_RESET;
            comp_reg <= mvf_pkg::COMP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                mvf_pkg::REG_SOURCE_SYSTEM:    sys_reg  <= cfg_data;
                mvf_pkg::REG_SOURCE_COMPONENT: comp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= mvf_pkg::CRC_INIT;
            seq_reg   <= 8'd0;
            rem_reg   <= 8'd0;
            extra_reg <= 8'd0;
            open_reg  <= 1'b0;
            cnt_reg   <= '0;
            end_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            seq_reg   <= seq_next;
            rem_reg   <= rem_next;
            extra_reg <= extra_next;
            open_reg  <= open_next;
            cnt_reg   <= cnt_next;
            end_reg   <= end_next;
            err_reg   <= err_next;
        end
    end

    // result bytes carry no reset
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mvf_pkg::RESULTS_MAX; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    // an accepted transaction always leaves results pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after accepted transaction");

    // the input side only stalls while results are pending
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("stall with empty result buffer");

    // an error result is a single zero byte that never closes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> cnt_reg == mvf_pkg::CNT_WIDTH'(1) && out_byte == 8'd0 && !frame_end)
        else $error("malformed error result");

    // an open frame always has payload bytes to come
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> rem_reg != 8'd0)
        else $error("open frame with no bytes remaining");

endmodule

@@ tb/mavlink_v1_framer_tb.sv @@
// self-checking testbench for the mavlink v1 framer: header, payload echo and x.25 checksum
module mavlink_v1_framer_tb;

    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD   = 80;

    typedef struct {
        logic       cmd;
        logic [7:0] msg_id;
        logic [7:0] extra;
        logic [7:0] len;
        logic [7:0] data;
    } frame_request_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       err;
    } frame_byte_t;

    logic                                clk            = 1'b0;
    logic                                rst_n          = 1'b0;
    logic                                cfg_write_en   = 1'b0;
    logic [mvf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index      = '0;
    logic [mvf_pkg::CFG_DATA_WIDTH-1:0]  cfg_data       = '0;
    logic                                in_valid       = 1'b0;
    logic                                in_stall;
    logic                                command        = mvf_pkg::CMD_START;
    logic [7:0]                          message_id     = 8'h00;
    logic [7:0]                          crc_extra      = 8'h00;
    logic [7:0]                          payload_length = 8'h00;
    logic [7:0]                          data_byte      = 8'h00;
    logic                                out_valid;
    logic                                out_stall      = 1'b0;
    logic [7:0]                          out_byte;
    logic                                frame_end;
    logic                                error;

    // stimulus queue and the bytes the framer still owes us
    frame_request_t frame_requests[$];
    frame_byte_t    frame_bytes_due[$];

    // predicted framer state
    logic [7:0]  exp_system;
    logic [7:0]  exp_component;
    logic [15:0] exp_crc;
    logic [7:0]  exp_sequence;
    logic [7:0]  exp_left;
    logic [7:0]  exp_extra;
    logic        exp_open;

    // bookkeeping
    logic req_taken         = 1'b0;
    int   requests_queued   = 0;
    int   requests_taken    = 0;
    int   bytes_owed        = 0;
    int   bytes_checked     = 0;
    int   frames_closed     = 0;
    int   orphan_errors     = 0;
    int   starts_queued     = 0;
    int   mismatch_count    = 0;
    int   stuck_cycles      = 0;
    int   gen_left          = 0;
    bit   sender_idles      = 1'b1;
    bit   receiver_idles    = 1'b1;
    int   hold_asks         = 0;
    int   hold_served       = 0;
    int   hold_count        = 0;
    int   send_gap          = 0;
    int   recv_gap          = 0;

    mavlink_v1_framer DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .message_id     (message_id),
        .crc_extra      (crc_extra),
        .payload_length (payload_length),
        .data_byte      (data_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .frame_end      (frame_end),
        .error          (error)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // bitwise reflected x.25 step, polynomial 0x8408
    function automatic logic [15:0] x25_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end
        return r;
    endfunction

    task automatic owe_byte(input logic [7:0] value, input logic last, input logic err);
        frame_byte_t fb;
        fb.value = value;
        fb.last  = last;
        fb.err   = err;
        frame_bytes_due.insert(frame_bytes_due.size(), fb);
        bytes_owed++;
    endtask

    task automatic owe_header_byte(input logic [7:0] value);
        exp_crc = x25_step(exp_crc, value);
        owe_byte(value, 1'b0, 1'b0);
    endtask

    // fold the extra byte in and owe the checksum, low byte first
    task automatic owe_checksum();
        exp_crc = x25_step(exp_crc, exp_extra);
        owe_byte(exp_crc[7:0], 1'b0, 1'b0);
        owe_byte(exp_crc[15:8], 1'b1, 1'b0);
        exp_open = 1'b0;
    endtask

    task automatic predict_frame_bytes(input frame_request_t rq);
        if (rq.cmd == mvf_pkg::CMD_START)
        begin
            exp_crc   = mvf_pkg::CRC_INIT;
            exp_extra = rq.extra;
            exp_left  = rq.len;
            owe_byte(mvf_pkg::STX_BYTE, 1'b0, 1'b0);
            owe_header_byte(rq.len);
            owe_header_byte(exp_sequence);
            owe_header_byte(exp_system);
            owe_header_byte(exp_component);
            owe_header_byte(rq.msg_id);
            exp_sequence = exp_sequence + 8'd1;
            exp_open     = 1'b1;
            if (exp_left == 8'd0)
            begin
                owe_checksum();
            end
        end
        else if (!exp_open)
        begin
            owe_byte(8'h00, 1'b0, 1'b1);
        end
        else
        begin
            exp_crc = x25_step(exp_crc, rq.data);
            owe_byte(rq.data, 1'b0, 1'b0);
            exp_left = exp_left - 8'd1;
            if (exp_left == 8'd0)
            begin
                owe_checksum();
            end
        end
    endtask

    // monitor: register writes, output checks and prediction on input transactions
    always @(posedge clk or negedge rst_n)
    begin : monitor
        frame_request_t rq;
        frame_byte_t    fb;
        if (!rst_n)
        begin
            exp_system    = mvf_pkg::SYS_RESET;
            exp_component = mvf_pkg::COMP_RESET;
            exp_crc       = mvf_pkg::CRC_INIT;
            exp_sequence  = 8'd0;
            exp_left      = 8'd0;
            exp_extra     = 8'd0;
            exp_open      = 1'b0;
            req_taken    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == mvf_pkg::REG_SOURCE_SYSTEM)
                    exp_system = cfg_data;
                else if (cfg_index == mvf_pkg::REG_SOURCE_COMPONENT)
                    exp_component = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $display("%0t: expected no output byte, actual %h (end %b, error %b)",
                             $time, out_byte, frame_end, error);
                    mismatch_count++;
                end
                else
                begin
                    fb = frame_bytes_due.pop_front();
                    bytes_owed--;
                    bytes_checked++;
                    if (out_byte !== fb.value)
                    begin
                        $display("%0t: out_byte expected %h actual %h", $time, fb.value, out_byte);
                        mismatch_count++;
                    end
                    if (frame_end !== fb.last)
                    begin
                        $display("%0t: frame_end expected %b actual %b", $time, fb.last, frame_end);
                        mismatch_count++;
                    end
                    if (error !== fb.err)
                    begin
                        $display("%0t: error expected %b actual %b", $time, fb.err, error);
                        mismatch_count++;
                    end
                    if (fb.last)
                        frames_closed++;
                    if (fb.err)
                        orphan_errors++;
                end
            end
            if (in_valid && !in_stall)
            begin
                rq.cmd    = command;
                rq.msg_id = message_id;
                rq.extra  = crc_extra;
                rq.len    = payload_length;
                rq.data   = data_byte;
                predict_frame_bytes(rq);
                requests_taken++;
            end
            req_taken <= in_valid && !in_stall;
        end
    end

    // sender: offers queued requests, holds a payload until it is taken
    always @(negedge clk)
    begin : sender
        frame_request_t rq;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !req_taken)
        begin
            // transaction still waiting, payload stays put
        end
        else if (send_gap != 0)
        begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end
        else if (frame_requests.size() == 0)
        begin
            in_valid <= 1'b0;
        end
        else if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            send_gap <= int'($urandom_range(0, 9));
            in_valid <= 1'b0;
        end
        else
        begin
            rq = frame_requests.pop_front();
            command        <= rq.cmd;
            message_id     <= rq.msg_id;
            crc_extra      <= rq.extra;
            payload_length <= rq.len;
            data_byte      <= rq.data;
            in_valid       <= 1'b1;
        end
    end

    // receiver: random stall bursts, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_count != 0)
        begin
            hold_count <= hold_count - 1;
            out_stall  <= 1'b1;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served <= hold_served + 1;
            hold_count  <= LONG_HOLD - 1;
            out_stall   <= 1'b1;
        end
        else if (recv_gap != 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_stall <= 1'b1;
        end
        else if (receiver_idles && $urandom_range(0, 4) == 0)
        begin
            recv_gap  <= int'($urandom_range(0, 9));
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("mavlink_v1_framer_tb: done, errors");
            $finish;
        end
    end

    task automatic push_start(input logic [7:0] len, input logic [7:0] msg, input logic [7:0] extra);
        frame_request_t rq;
        rq.cmd    = mvf_pkg::CMD_START;
        rq.msg_id = msg;
        rq.extra  = extra;
        rq.len    = len;
        rq.data   = 8'($urandom_range(0, 255));
        frame_requests.insert(frame_requests.size(), rq);
        requests_queued++;
        starts_queued++;
        gen_left = int'(len);
    endtask

    task automatic push_payload(input logic [7:0] data);
        frame_request_t rq;
        rq.cmd    = mvf_pkg::CMD_PAYLOAD;
        rq.msg_id = 8'($urandom_range(0, 255));
        rq.extra  = 8'($urandom_range(0, 255));
        rq.len    = 8'($urandom_range(0, 255));
        rq.data   = data;
        frame_requests.insert(frame_requests.size(), rq);
        requests_queued++;
        if (gen_left > 0)
            gen_left--;
    endtask

    // mostly complete frames of short length, some cut short, some orphan payload bytes
    task automatic queue_random_traffic(input int count);
        int added;
        int pick;
        int len;
        int cut;
        added = 0;
        while (added < count)
        begin
            pick = int'($urandom_range(0, 9));
            if (pick == 0 && gen_left == 0)
            begin
                push_payload(8'($urandom_range(0, 255)));
                added++;
            end
            else
            begin
                pick = int'($urandom_range(0, 19));
                if (pick < 12)
                    len = int'($urandom_range(0, 4));
                else if (pick < 19)
                    len = int'($urandom_range(5, 24));
                else
                    len = int'($urandom_range(25, 60));
                cut = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, len)) : len;
                push_start(8'(len), 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                added++;
                for (int k = 0; k < cut; k++)
                begin
                    push_payload(8'($urandom_range(0, 255)));
                    added++;
                end
            end
        end
    endtask

    // wait until every request is in and every owed byte is out
    task automatic drain();
        wait (requests_taken == requests_queued);
        wait (bytes_owed == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_reg(input logic [mvf_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [7:0] value);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // run sequence
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed frames with the reset ids
        push_start(8'd0, 8'h00, 8'h00);
        push_start(8'd0, 8'hFF, 8'hFF);
        push_payload(8'hFF);
        push_start(8'd1, 8'h01, 8'h32);
        push_payload(8'hFF);
        push_payload(8'h00);
        push_start(8'd3, 8'h55, 8'hAA);
        push_payload(8'h00);
        push_payload(8'hA5);
        push_payload(8'h5A);
        push_start(8'd2, 8'h7F, 8'h80);
        push_payload(8'h11);
        push_start(8'd2, 8'h80, 8'h7F);
        push_payload(8'h22);
        push_payload(8'h33);
        push_start(8'd1, 8'h12, 8'h34);
        push_start(8'd0, 8'h56, 8'h78);
        push_payload(8'hC3);
        drain();

        // ids at zero, random traffic with idling on both sides
        write_reg(mvf_pkg::REG_SOURCE_SYSTEM, 8'd0);
        write_reg(mvf_pkg::REG_SOURCE_COMPONENT, 8'd0);
        queue_random_traffic(50);
        drain();

        // ids at the top, receiver holds off while frames pile up
        write_reg(mvf_pkg::REG_SOURCE_SYSTEM, 8'd255);
        write_reg(mvf_pkg::REG_SOURCE_COMPONENT, 8'd255);
        hold_asks++;
        push_start(8'd24, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int k = 0; k < 24; k++)
            push_payload(8'($urandom_range(0, 255)));
        queue_random_traffic(30);
        drain();

        // a maximum-length header cut short, then a longer frame among random traffic
        write_reg(mvf_pkg::REG_SOURCE_SYSTEM, 8'($urandom_range(0, 255)));
        write_reg(mvf_pkg::REG_SOURCE_COMPONENT, 8'($urandom_range(0, 255)));
        push_start(8'd255, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int k = 0; k < 8; k++)
            push_payload(8'($urandom_range(0, 255)));
        push_start(8'd40, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        for (int k = 0; k < 40; k++)
            push_payload(8'($urandom_range(0, 255)));
        queue_random_traffic(10);
        drain();

        // closing stretch at full rate
        write_reg(mvf_pkg::REG_SOURCE_SYSTEM, 8'd0);
        write_reg(mvf_pkg::REG_SOURCE_COMPONENT, 8'd255);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        queue_random_traffic(40);
        drain();

        $display("summary: %0d input transactions, %0d starts, %0d output bytes checked",
                 requests_taken, starts_queued, bytes_checked);
        $display("summary: %0d frames closed, %0d orphan payload errors, %0d mismatches",
                 frames_closed, orphan_errors, mismatch_count);
        if (mismatch_count == 0 && frame_bytes_due.size() == 0)
            $display("mavlink_v1_framer_tb: done, clean");
        else
            $display("mavlink_v1_framer_tb: done, errors");
        $finish;
    end

endmodule
